/* sv/jtdm_pkg.sv */
// Shared types and constants of the joystick tank drive mixer.
// No dependencies; the core and the testbench refer to it by scoped names.
package jtdm_pkg;

  typedef logic signed [7:0] power_t;

  localparam int unsigned CfgIndexWidth = 2;
  localparam int unsigned BurstLen = 16;
  localparam int unsigned ByteCountWidth = 4;

  localparam logic [CfgIndexWidth-1:0] RegDeadband = 2'd0;
  localparam logic [CfgIndexWidth-1:0] RegChangeThreshold = 2'd1;
  localparam logic [CfgIndexWidth-1:0] RegFirstDeviceId = 2'd2;
  localparam logic [CfgIndexWidth-1:0] RegSecondDeviceId = 2'd3;

  localparam logic [6:0] DeadbandReset = 7'd10;
  localparam logic [7:0] ChangeThresholdReset = 8'd2;
  localparam logic [7:0] FirstDeviceIdReset = 8'd1;
  localparam logic [7:0] SecondDeviceIdReset = 8'd2;

  localparam logic [7:0] MotorCmd = 8'd4;

  localparam logic [1:0] FieldDevice = 2'd0;
  localparam logic [1:0] FieldCmd = 2'd1;
  localparam logic [1:0] FieldMotor = 2'd2;
  localparam logic [1:0] FieldPower = 2'd3;

endpackage

/* sv/joystick_tank_drive_mixer_core.sv */
// Joystick tank drive mixer: sample register, quadrant mix, deadband, change test
// and a sixteen-byte command serializer. Depends on jtdm_pkg.
//
// Usage:
//   Sample channel: stick_x, stick_y with sample_valid / sample_stall. A request is
//   taken when sample_valid is high and sample_stall is low.
//   Byte channel: tx_byte, last_byte with byte_valid / byte_stall. A burst is sixteen
//   bytes, one per cycle while not stalled; last_byte marks the sixteenth.
//   Config channel: cfg_valid / cfg_ready with cfg_index and cfg_data; cfg_ready is
//   always high. Write only while the block is idle.
// Order: a sample is registered, then mixed in the next cycle; when it moves on and
//   sends, the busy register is set and its first byte is valid while busy is high.
// Throughput: a burst holds the serializer until its last byte is accepted; a sample
//   that would also send waits in the input register and moves on with that byte.
//   Samples that send nothing pass at one per cycle, even during a burst.
// Reset (rst, synchronous): registers return to deadband 10, threshold 2, devices
//   1 and 2; previous powers clear to zero; no burst is pending.
// A stalled byte holds; the serializer stops, and so does the sample register if its sample would send.
module joystick_tank_drive_mixer_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       sample_valid,
  output logic       sample_stall,
  input  logic [7:0] stick_x,
  input  logic [7:0] stick_y,
  output logic       byte_valid,
  input  logic       byte_stall,
  output logic [7:0] tx_byte,
  output logic       last_byte,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [jtdm_pkg::CfgIndexWidth-1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  logic [6:0] deadband;
  logic [7:0] change_threshold;
  logic [7:0] first_device_id;
  logic [7:0] second_device_id;

  logic s1_valid;
  logic signed [7:0] x_r;
  logic signed [7:0] y_r;

  jtdm_pkg::power_t prev_left_power;
  jtdm_pkg::power_t prev_right_power;

  logic busy;
  logic [jtdm_pkg::ByteCountWidth-1:0] cnt;
  jtdm_pkg::power_t burst_e0;
  jtdm_pkg::power_t burst_e1;

  logic signed [9:0] mix0, mix1;
  jtdm_pkg::power_t e0, e1;
  logic send;
  logic burst_done;
  logic s1_advance;

  function automatic jtdm_pkg::power_t sat8(input logic signed [9:0] v);
    if (v > 10'sd127) begin
      return 8'sh7f;
    end else if (v < -10'sd128) begin
      return 8'sh80;
    end
    return v[7:0];
  endfunction

  function automatic jtdm_pkg::power_t dead(input jtdm_pkg::power_t v,
                                            input logic [6:0] db);
    logic signed [8:0] v9;
    logic signed [8:0] db9;
    v9 = {v[7], v};
    db9 = {2'b00, db};
    if ((v9 > -db9) && (v9 < db9)) begin
      return 8'sd0;
    end
    return v;
  endfunction

  function automatic logic moved(input jtdm_pkg::power_t a, input jtdm_pkg::power_t b,
                                 input logic [7:0] th);
    logic signed [9:0] d;
    logic [8:0] mag;
    d = {{2{a[7]}}, a} - {{2{b[7]}}, b};
    mag = d[9] ? 9'(-d) : d[8:0];
    return mag > {1'b0, th};
  endfunction

  always_comb begin
    logic signed [9:0] x10, y10;
    x10 = {{2{x_r[7]}}, x_r};
    y10 = {{2{y_r[7]}}, y_r};
    if (!y_r[7]) begin
      if (!x_r[7]) begin
        mix0 = y10;
        mix1 = y10 - x10;
      end else begin
        mix0 = y10 + x10;
        mix1 = y10;
      end
    end else begin
      if (!x_r[7]) begin
        mix0 = y10;
        mix1 = y10 + x10;
      end else begin
        mix0 = y10 - x10;
        mix1 = y10;
      end
    end
  end

  assign e0 = dead(sat8(mix0), deadband);
  assign e1 = dead(sat8(mix1), deadband);
  assign send = moved(prev_left_power, e0, change_threshold)
             || moved(prev_right_power, e1, change_threshold);

  assign burst_done = busy && !byte_stall
                   && (cnt == jtdm_pkg::ByteCountWidth'(jtdm_pkg::BurstLen - 1));
  assign s1_advance = s1_valid && (!busy || burst_done || !send);
  assign sample_stall = s1_valid && !s1_advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      deadband <= jtdm_pkg::DeadbandReset;
      change_threshold <= jtdm_pkg::ChangeThresholdReset;
      first_device_id <= jtdm_pkg::FirstDeviceIdReset;
      second_device_id <= jtdm_pkg::SecondDeviceIdReset;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        jtdm_pkg::RegDeadband: deadband <= cfg_data[6:0];
        jtdm_pkg::RegChangeThreshold: change_threshold <= cfg_data;
        jtdm_pkg::RegFirstDeviceId: first_device_id <= cfg_data;
        jtdm_pkg::RegSecondDeviceId: second_device_id <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sample_valid && !sample_stall) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_valid && !sample_stall) begin
      x_r <= stick_x;
      y_r <= stick_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_left_power <= '0;
      prev_right_power <= '0;
      busy <= 1'b0;
      cnt <= '0;
    end else begin
      if (s1_advance) begin
        prev_left_power <= e0;
        prev_right_power <= e1;
      end
      if (s1_advance && send) begin
        busy <= 1'b1;
        cnt <= '0;
      end else begin
        if (busy && !byte_stall) begin
          cnt <= cnt + 1'b1;
        end
        if (burst_done) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && send) begin
      burst_e0 <= e0;
      burst_e1 <= e1;
    end
  end

  always_comb begin
    unique case (cnt[1:0])
      jtdm_pkg::FieldDevice: tx_byte = cnt[3] ? second_device_id : first_device_id;
      jtdm_pkg::FieldCmd: tx_byte = jtdm_pkg::MotorCmd;
      jtdm_pkg::FieldMotor: tx_byte = {7'd0, cnt[2]};
      jtdm_pkg::FieldPower: tx_byte = cnt[2] ? burst_e1 : burst_e0;
      default: tx_byte = '0;
    endcase
  end

  assign byte_valid = busy;
  assign last_byte = (cnt == jtdm_pkg::ByteCountWidth'(jtdm_pkg::BurstLen - 1));

endmodule

/* sv/jtdm_checker.sv */
// Port-level checks of the joystick tank drive mixer, bound to the core.
// Depends on joystick_tank_drive_mixer_core.
module jtdm_checker (
  input logic       clk,
  input logic       rst,
  input logic       byte_valid,
  input logic       byte_stall,
  input logic [7:0] tx_byte,
  input logic       last_byte,
  input logic       cfg_ready
);

  a_byte_hold: assert property (@(posedge clk) disable iff (rst)
    byte_valid && byte_stall |=> byte_valid && $stable(tx_byte))
    else $error("stalled byte request changed");

  a_burst_continues: assert property (@(posedge clk) disable iff (rst)
    byte_valid && !byte_stall && !last_byte |=> byte_valid)
    else $error("burst ended before its last byte");

  a_burst_starts_device: assert property (@(posedge clk) disable iff (rst)
    byte_valid && !byte_stall && last_byte ##1 byte_valid |-> !last_byte)
    else $error("new burst opened on a last byte");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !byte_valid && cfg_ready)
    else $error("byte request pending after reset");

endmodule

bind joystick_tank_drive_mixer_core jtdm_checker u_jtdm_checker (
  .clk(clk),
  .rst(rst),
  .byte_valid(byte_valid),
  .byte_stall(byte_stall),
  .tx_byte(tx_byte),
  .last_byte(last_byte),
  .cfg_ready(cfg_ready)
);

/* tb/jtdm_burst_checker.sv */
// Checker for the joystick tank drive mixer: watches the sample, byte and config channels,
// predicts each command burst and compares it byte by byte with what the core sends.
// Depends on jtdm_pkg for the register indexes, the motor command byte and the power type.
module jtdm_burst_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       sample_valid,
  input  logic       sample_stall,
  input  logic [7:0] stick_x,
  input  logic [7:0] stick_y,
  input  logic       byte_valid,
  input  logic       byte_stall,
  input  logic [7:0] tx_byte,
  input  logic       last_byte,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [jtdm_pkg::CfgIndexWidth-1:0] cfg_index,
  input  logic [7:0] cfg_data,
  output int         mismatch_count,
  output int         bytes_outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] tx;
    logic       last;
  } cmd_byte_t;

  cmd_byte_t expected_bytes[$];

  logic [6:0] deadband_q;
  logic [7:0] threshold_q;
  logic [7:0] dev_a_q;
  logic [7:0] dev_b_q;
  jtdm_pkg::power_t left_prev;
  jtdm_pkg::power_t right_prev;

  function automatic int clamp_power(input int v);
    if (v > 127) return 127;
    if (v < -128) return -128;
    return v;
  endfunction

  function automatic int zero_band(input int v, input logic [6:0] band);
    int b;
    b = int'(band);
    if (v > -b && v < b) return 0;
    return v;
  endfunction

  task automatic mix_sample(input logic [7:0] sx, input logic [7:0] sy);
    int x;
    int y;
    int left;
    int right;
    int dl;
    int dr;
    int i;
    logic [7:0] dev;
    logic [7:0] pwr;
    x = int'($signed(sx));
    y = int'($signed(sy));
    if (y >= 0) begin
      if (x >= 0) begin
        left = y;
        right = y - x;
      end else begin
        left = y + x;
        right = y;
      end
    end else begin
      if (x >= 0) begin
        left = y;
        right = y + x;
      end else begin
        left = y - x;
        right = y;
      end
    end
    left = zero_band(clamp_power(left), deadband_q);
    right = zero_band(clamp_power(right), deadband_q);
    dl = int'(left_prev) - left;
    dr = int'(right_prev) - right;
    if (dl < 0) dl = -dl;
    if (dr < 0) dr = -dr;
    left_prev = jtdm_pkg::power_t'(left);
    right_prev = jtdm_pkg::power_t'(right);
    if (dl > int'(threshold_q) || dr > int'(threshold_q)) begin
      for (i = 0; i < 4; i++) begin
        dev = (i < 2) ? dev_a_q : dev_b_q;
        pwr = i[0] ? right[7:0] : left[7:0];
        expected_bytes.push_back('{tx: dev, last: 1'b0});
        expected_bytes.push_back('{tx: jtdm_pkg::MotorCmd, last: 1'b0});
        expected_bytes.push_back('{tx: {7'd0, i[0]}, last: 1'b0});
        expected_bytes.push_back('{tx: pwr, last: (i == 3)});
      end
    end
  endtask

  always @(posedge clk) begin : track
    cmd_byte_t want;
    if (rst) begin
      deadband_q = jtdm_pkg::DeadbandReset;
      threshold_q = jtdm_pkg::ChangeThresholdReset;
      dev_a_q = jtdm_pkg::FirstDeviceIdReset;
      dev_b_q = jtdm_pkg::SecondDeviceIdReset;
      left_prev = '0;
      right_prev = '0;
      expected_bytes.delete();
      mismatch_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          jtdm_pkg::RegDeadband: deadband_q = cfg_data[6:0];
          jtdm_pkg::RegChangeThreshold: threshold_q = cfg_data;
          jtdm_pkg::RegFirstDeviceId: dev_a_q = cfg_data;
          jtdm_pkg::RegSecondDeviceId: dev_b_q = cfg_data;
          default: ;
        endcase
      end
      if (sample_valid && !sample_stall) mix_sample(stick_x, stick_y);
      if (byte_valid && !byte_stall) begin
        if (expected_bytes.size() == 0) begin
          $error("unexpected byte: tx_byte %0h last_byte %0b", tx_byte, last_byte);
          mismatch_count++;
        end else begin
          want = expected_bytes.pop_front();
          if (tx_byte !== want.tx) begin
            $error("tx_byte mismatch: expected %0h actual %0h", want.tx, tx_byte);
            mismatch_count++;
          end
          if (last_byte !== want.last) begin
            $error("last_byte mismatch: expected %0b actual %0b", want.last, last_byte);
            mismatch_count++;
          end
        end
      end
    end
    bytes_outstanding = expected_bytes.size();
  end

endmodule

/* tb/tb_joystick_tank_drive_mixer_core.sv */
// Top of the joystick tank drive mixer testbench: clock, reset, joystick samples, register
// settings and random stalls. Depends on jtdm_pkg, the core and jtdm_burst_checker.
module tb_joystick_tank_drive_mixer_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IdleLimit = 3000;
  localparam int HoldCycles = 300;
  localparam int DrainCycles = 8;

  logic       clk;
  logic       rst;
  logic       sample_valid;
  logic       sample_stall;
  logic [7:0] stick_x;
  logic [7:0] stick_y;
  logic       byte_valid;
  logic       byte_stall;
  logic [7:0] tx_byte;
  logic       last_byte;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [jtdm_pkg::CfgIndexWidth-1:0] cfg_index;
  logic [7:0] cfg_data;

  int   mismatch_count;
  int   bytes_outstanding;
  int   quiet_cycles;
  bit   idle_on;
  bit   hold_req;
  bit   hold_done;
  logic [7:0] last_x;
  logic [7:0] last_y;

  joystick_tank_drive_mixer_core i_dut (
    .clk         (clk),
    .rst         (rst),
    .sample_valid(sample_valid),
    .sample_stall(sample_stall),
    .stick_x     (stick_x),
    .stick_y     (stick_y),
    .byte_valid  (byte_valid),
    .byte_stall  (byte_stall),
    .tx_byte     (tx_byte),
    .last_byte   (last_byte),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  jtdm_burst_checker i_checker (
    .clk              (clk),
    .rst              (rst),
    .sample_valid     (sample_valid),
    .sample_stall     (sample_stall),
    .stick_x          (stick_x),
    .stick_y          (stick_y),
    .byte_valid       (byte_valid),
    .byte_stall       (byte_stall),
    .tx_byte          (tx_byte),
    .last_byte        (last_byte),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .mismatch_count   (mismatch_count),
    .bytes_outstanding(bytes_outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // byte side: random stall bursts, one long hold-off on request
  initial begin
    byte_stall <= 1'b0;
    forever begin
      if (hold_req && !hold_done) begin
        byte_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
        hold_done = 1'b1;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        byte_stall <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end else begin
        byte_stall <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (sample_valid && !sample_stall) || (byte_valid && !byte_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= IdleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send_sample(input logic [7:0] x, input logic [7:0] y);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      sample_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    sample_valid <= 1'b1;
    stick_x <= x;
    stick_y <= y;
    do @(posedge clk); while (sample_stall);
    last_x = x;
    last_y = y;
  endtask

  task automatic next_sample(output logic [7:0] x, output logic [7:0] y);
    case ($urandom_range(0, 9))
      0, 1: begin
        x = 8'($urandom);
        y = 8'($urandom);
      end
      2, 3: begin
        x = last_x;
        y = last_y;
      end
      4, 5: begin
        x = last_x + 8'($urandom_range(0, 6)) - 8'd3;
        y = last_y + 8'($urandom_range(0, 6)) - 8'd3;
      end
      default: begin
        x = 8'($urandom_range(0, 200) - 100);
        y = 8'($urandom_range(0, 200) - 100);
      end
    endcase
  endtask

  task automatic run_random(input int count);
    logic [7:0] x;
    logic [7:0] y;
    repeat (count) begin
      next_sample(x, y);
      send_sample(x, y);
    end
  endtask

  // drop valid, wait out every pending byte, then the pipeline
  task automatic settle();
    sample_valid <= 1'b0;
    do @(posedge clk); while (bytes_outstanding != 0);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [jtdm_pkg::CfgIndexWidth-1:0] idx,
                           input logic [7:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic program_regs(input logic [7:0] band, input logic [7:0] thresh,
                              input logic [7:0] dev_a, input logic [7:0] dev_b);
    cfg_write(jtdm_pkg::RegDeadband, band);
    cfg_write(jtdm_pkg::RegChangeThreshold, thresh);
    cfg_write(jtdm_pkg::RegFirstDeviceId, dev_a);
    cfg_write(jtdm_pkg::RegSecondDeviceId, dev_b);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int corner[22][2];
    int k;
    corner = '{
      '{0, 0}, '{100, 100}, '{-100, -100}, '{100, -100}, '{-100, 100},
      '{0, 100}, '{100, 0}, '{-128, -128}, '{127, 127}, '{-128, 127},
      '{127, -128}, '{127, -128}, '{5, 5}, '{9, -9}, '{10, 10},
      '{-10, -10}, '{-11, 11}, '{0, -128}, '{-1, 127}, '{127, -1},
      '{-128, 0}, '{0, 0}
    };
    idle_on = 1'b1;
    hold_req = 1'b0;
    last_x = '0;
    last_y = '0;
    rst <= 1'b1;
    sample_valid <= 1'b0;
    stick_x <= '0;
    stick_y <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= jtdm_pkg::RegDeadband;
    cfg_data <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (k = 0; k < 22; k++) send_sample(8'(corner[k][0]), 8'(corner[k][1]));
    run_random(60);
    settle();

    program_regs(8'd0, 8'd0, 8'd0, 8'd255);
    hold_req = 1'b1;
    run_random(60);
    settle();

    program_regs(8'hff, 8'd255, 8'hab, 8'h5c);
    run_random(40);
    settle();

    program_regs(8'd100, 8'd200, 8'd255, 8'd0);
    run_random(40);
    settle();

    program_regs(8'($urandom_range(0, 40)), 8'($urandom_range(0, 30)),
                 8'($urandom), 8'($urandom));
    run_random(100);
    settle();

    idle_on = 1'b0;
    program_regs(8'd10, 8'd2, 8'd1, 8'd2);
    run_random(80);
    settle();

    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/jtdm_pkg.sv
sv/joystick_tank_drive_mixer_core.sv
sv/jtdm_checker.sv
tb/jtdm_burst_checker.sv
tb/tb_joystick_tank_drive_mixer_core.sv
